### src/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse block.
// Used by every module under src; depends on nothing.
package mi3_pkg;

  localparam int W_IN     = 16;            // Q4.12 matrix entry
  localparam int W_PROD   = 2 * W_IN;      // 2x2 minor product
  localparam int W_COF    = W_PROD + 1;    // cofactor, Q9.24
  localparam int W_DET    = 49;            // determinant, Q13.36
  localparam int W_DPROD  = W_IN + W_COF;  // row-0 entry times cofactor
  localparam int W_OUT    = 32;            // Q16.16 result
  localparam int FRAC_SH  = 28;            // quotient scaling
  localparam int W_MAG    = W_COF - 1;     // cofactor magnitude
  localparam int W_NUM    = W_MAG + FRAC_SH;
  localparam int Q_BITS   = W_OUT - 1;     // quotient bits below saturation
  localparam int W_SH     = W_DET + Q_BITS;
  localparam int DIV_LAT  = Q_BITS + 1;    // prep stage plus one per bit
  localparam int N_ENT    = 9;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef logic signed [W_IN-1:0]  entry_t;
  typedef logic signed [W_COF-1:0] cof_t;
  typedef logic signed [W_DET-1:0] det_t;
  typedef logic signed [W_OUT-1:0] inv_t;

  // One classified matrix handed from the front part to the back part.
  typedef struct packed {
    cof_t [N_ENT-1:0] cof;   // cofactor of entry r,c at index r*3+c
    det_t             det;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam inv_t INV_MAX = inv_t'({1'b0, {(W_OUT-1){1'b1}}});
  localparam inv_t INV_MIN = inv_t'({1'b1, {(W_OUT-1){1'b0}}});

endpackage

### src/matrix_inverse_3x3.sv
// Top level of the 3x3 fixed-point matrix inverse by the adjugate method.
// Depends on mi3_pkg, mi3_front, mi3_fifo and mi3_back.
//
// Each input beat carries one 3x3 matrix of signed Q4.12 entries; each output
// beat carries its inverse in signed Q16.16 (truncated toward zero, saturated
// to 32 bits), the exact determinant in Q13.36 and a singular flag. A zero
// determinant gives singular = 1 with all inverse entries zero. The block
// accepts one matrix per clock while in_ready is high, since every stage
// including the nine dividers is fully pipelined, and keeps up to 41 matrices
// in flight. When nothing stalls, a matrix passes four front stages that build
// the cofactors and determinant (the first one loads at the input beat), the
// queue, then 32 divider stages (one setup stage plus one quotient bit per stage
// for 31 bits) and the output register. The front and back parts stall
// independently; the four-entry queue between them absorbs short output stalls
// while new beats keep flowing in.
module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  entry_t a00, a01, a02, a10, a11, a12, a20, a21, a22,
  output logic   out_valid,
  input  logic   out_ready,
  output inv_t   inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
  output det_t   determinant,
  output logic   singular
);

  entry_t [N_ENT-1:0] m;
  inv_t   [N_ENT-1:0] inv;
  logic               front_en, front_valid, push, pop;
  work_t              front_work, q_work;
  fifo_stat_t         qstat;

  assign m = {a22, a21, a20, a12, a11, a10, a02, a01, a00};

  // The front advances unless its last stage holds a matrix the queue can't take.
  assign front_en = !(front_valid && qstat.full);
  assign in_ready = front_en;
  assign push     = front_valid && !qstat.full;

  mi3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (front_en),
    .in_beat   (in_valid && in_ready),
    .m         (m),
    .out_valid (front_valid),
    .out_work  (front_work)
  );

  mi3_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_work),
    .pop   (pop),
    .rdata (q_work),
    .stat  (qstat)
  );

  mi3_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_avail    (!qstat.empty),
    .work        (q_work),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .inv         (inv),
    .determinant (determinant),
    .singular    (singular)
  );

  assign inv00 = inv[0];
  assign inv01 = inv[1];
  assign inv02 = inv[2];
  assign inv10 = inv[3];
  assign inv11 = inv[4];
  assign inv12 = inv[5];
  assign inv20 = inv[6];
  assign inv21 = inv[7];
  assign inv22 = inv[8];

  // The queue can never report full and empty at once.
  a_q_stat: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty together");

  // A singular result carries a zero determinant and zero diagonal entries.
  a_singular: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> determinant == '0 && inv00 == '0 && inv11 == '0
      && inv22 == '0)
    else $error("singular result with nonzero fields");

  // A nonsingular result carries a nonzero determinant.
  a_nonsingular: assert property (@(posedge clk) disable iff (rst)
    out_valid && !singular |-> determinant != '0)
    else $error("zero determinant without singular flag");

endmodule

### src/mi3_front.sv
// Front part: forms the nine cofactors and the exact determinant in four stages.
// Depends on mi3_pkg.
module mi3_front import mi3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_beat,
  input  entry_t [N_ENT-1:0]     m,
  output logic                   out_valid,
  output work_t                  out_work
);

  logic signed [W_PROD-1:0] pa [N_ENT];
  logic signed [W_PROD-1:0] pb [N_ENT];
  entry_t [2:0]             row0_1, row0_2;
  cof_t [N_ENT-1:0]         cof2, cof3;
  logic signed [W_DPROD-1:0] dp [3];
  logic [3:0]               v;

  // Cyclic index order gives the cofactor sign for free.
  for (genvar r = 0; r < 3; r++) begin : g_r
    for (genvar c = 0; c < 3; c++) begin : g_c
      localparam int R1 = (r + 1) % 3;
      localparam int R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3;
      localparam int C2 = (c + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          pa[r*3+c] <= m[R1*3+C1] * m[R2*3+C2];
          pb[r*3+c] <= m[R1*3+C2] * m[R2*3+C1];
          cof2[r*3+c] <= W_COF'(pa[r*3+c]) - W_COF'(pb[r*3+c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row0_1 <= m[2:0];
      row0_2 <= row0_1;
      cof3   <= cof2;
      for (int j = 0; j < 3; j++) begin
        dp[j] <= row0_2[j] * cof2[j];
      end
      out_work.cof <= cof3;
      out_work.det <= W_DET'(dp[0] + dp[1] + dp[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], in_beat};
    end
  end

  assign out_valid = v[3];

endmodule

### src/mi3_fifo.sv
// Short queue that decouples the front part from the divider back part.
// Depends on mi3_pkg.
module mi3_fifo import mi3_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  work_t      wdata,
  input  logic       pop,
  output work_t      rdata,
  output fifo_stat_t stat
);

  work_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_AW:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  assign rdata      = mem[rptr];
  assign stat.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count == '0);

endmodule

### src/mi3_div.sv
// Pipelined restoring divider with one quotient bit per stage; it takes one
// item per cycle while en is high. Depends on mi3_pkg.
module mi3_div import mi3_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  cof_t              cof,
  input  det_t              det,
  output logic [Q_BITS-1:0] q,
  output logic              neg,
  output logic              sat
);

  logic [W_NUM-1:0]  rem  [DIV_LAT];
  logic [W_DET-1:0]  den  [DIV_LAT];
  logic [Q_BITS-1:0] qs   [DIV_LAT];
  logic              ng   [DIV_LAT];
  logic              st   [DIV_LAT];

  logic [W_MAG-1:0] cmag;
  logic [W_DET-1:0] dmag;
  logic [W_NUM-1:0] num;

  always_comb begin
    cmag = cof[W_COF-1] ? W_MAG'(-cof) : W_MAG'(cof);
    dmag = det[W_DET-1] ? W_DET'(-det) : W_DET'(det);
    num  = {cmag, {FRAC_SH{1'b0}}};
  end

  // Prep stage: a quotient of 2^31 or more saturates either way.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      den[0] <= dmag;
      qs[0]  <= '0;
      ng[0]  <= cof[W_COF-1] ^ det[W_DET-1];
      st[0]  <= W_SH'(num) >= {dmag, {Q_BITS{1'b0}}};
    end
  end

  for (genvar s = 1; s < DIV_LAT; s++) begin : g_stage
    localparam int K = Q_BITS - s;
    logic [W_SH-1:0] dsh;
    logic            ge;
    assign dsh = W_SH'(den[s-1]) << K;
    assign ge  = W_SH'(rem[s-1]) >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]    <= ge ? W_NUM'(W_SH'(rem[s-1]) - dsh) : rem[s-1];
        den[s]    <= den[s-1];
        qs[s]     <= qs[s-1] | (Q_BITS'(ge) << K);
        ng[s]     <= ng[s-1];
        st[s]     <= st[s-1];
      end
    end
  end

  assign q   = qs[DIV_LAT-1];
  assign neg = ng[DIV_LAT-1];
  assign sat = st[DIV_LAT-1];

endmodule

### src/mi3_back.sv
// Back part: nine dividers in lockstep, sign and saturation, output register.
// Depends on mi3_pkg and mi3_div.
module mi3_back import mi3_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_avail,
  input  work_t             work,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output inv_t [N_ENT-1:0]  inv,
  output det_t              determinant,
  output logic              singular
);

  logic              en;
  logic [DIV_LAT-1:0] v;
  det_t              det_d [DIV_LAT];
  logic [Q_BITS-1:0] q   [N_ENT];
  logic              neg [N_ENT];
  logic              sat [N_ENT];
  logic              zero_last;

  assign en  = !(out_valid && !out_ready);
  assign pop = in_avail && en;

  // Inverse entry r,c divides the cofactor of entry c,r.
  for (genvar r = 0; r < 3; r++) begin : g_r
    for (genvar c = 0; c < 3; c++) begin : g_c
      mi3_div u_div (
        .clk (clk),
        .en  (en),
        .cof (work.cof[c*3+r]),
        .det (work.det),
        .q   (q[r*3+c]),
        .neg (neg[r*3+c]),
        .sat (sat[r*3+c])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_d[0] <= work.det;
      for (int s = 1; s < DIV_LAT; s++) begin
        det_d[s] <= det_d[s-1];
      end
    end
  end

  assign zero_last = (det_d[DIV_LAT-1] == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      determinant <= det_d[DIV_LAT-1];
      singular    <= zero_last;
      for (int i = 0; i < N_ENT; i++) begin
        if (zero_last)    inv[i] <= '0;
        else if (sat[i])  inv[i] <= neg[i] ? INV_MIN : INV_MAX;
        else if (neg[i])  inv[i] <= -inv_t'({1'b0, q[i]});
        else              inv[i] <= inv_t'({1'b0, q[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[DIV_LAT-2:0], pop};
      out_valid <= v[DIV_LAT-1];
    end
  end

endmodule
